/* rtl/tcs_pkg.sv */
// shared types and command codes for the telnet command stripper
package tcs_pkg;

  // telnet command codes; IAC and the four option verbs steer the parser
  localparam logic [7:0] CMD_SE   = 8'd240;
  localparam logic [7:0] CMD_SB   = 8'd250;
  localparam logic [7:0] CMD_WILL = 8'd251;
  localparam logic [7:0] CMD_WONT = 8'd252;
  localparam logic [7:0] CMD_DO   = 8'd253;
  localparam logic [7:0] CMD_DONT = 8'd254;
  localparam logic [7:0] CMD_IAC  = 8'd255;

  // parser phase; the unused fourth code behaves as idle
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_CMD,
    PH_OPTION
  } phase_t;

  // reply expansion step in the back end
  typedef enum logic [1:0] {
    EX_IDLE,
    EX_VERB,
    EX_OPT
  } expand_t;

  // result channel codes
  typedef enum logic {
    CH_DATA  = 1'b0,
    CH_REPLY = 1'b1
  } channel_t;

  // one queued action: a data byte, or a refusal reply for an option
  typedef struct packed {
    logic       reply;
    logic       dont;
    logic [7:0] value;
  } action_t;

  // push request from the front end into the queue
  typedef struct packed {
    logic    valid;
    action_t act;
  } push_t;

endpackage

/* rtl/tcs_if.sv */
// valid/ready channel interfaces for received bytes and result items

interface tcs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface tcs_out_if;
  logic       valid;
  logic       ready;
  logic       out_channel;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_channel, output out_byte, output out_last,
                  input ready);
  modport sink (input valid, input out_channel, input out_byte, input out_last,
                output ready);
endinterface

/* rtl/telnet_command_stripper.sv */
// Telnet command stripper: removes IAC command sequences from a received byte
// stream, passes data bytes to the application (channel 0) and refuses every
// option negotiation with an IAC DONT/WONT option reply to the peer (channel 1).
// A parser takes one byte per cycle and pushes at most one action into a queue
// of QUEUE_DEPTH entries; the expander behind it drains one result item per
// cycle, while the output is free, into a registered output. A data byte yields
// one result item, a reply three, so the input sustains one byte per cycle and
// is held off only when a stalled output lets the queue fill. An accepted byte
// is written into the queue, then into the output register that offers it.
module telnet_command_stripper #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  tcs_in_if.sink    in_ch,
  tcs_out_if.source out_ch
);

  tcs_pkg::push_t   push;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  tcs_pkg::action_t q_data;

  // byte parser
  tcs_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push)
  );

  // action queue
  tcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (q_full),
    .pop     (q_pop),
    .q_valid (q_valid),
    .q_data  (q_data)
  );

  // reply expander and output register
  tcs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (q_pop),
    .res     (out_ch)
  );

`ifndef ASSERT_OFF
  // the parser never pushes into a full queue
  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !q_full)
    else $error("action pushed into full queue");

  // a data item is always the only result of its byte
  a_data_last : assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && (out_ch.out_channel == tcs_pkg::CH_DATA)) |-> out_ch.out_last)
    else $error("data item without last flag");

  // nothing is offered right after reset
  a_reset_quiet : assert property (@(posedge clk)
    rst |=> !out_ch.valid)
    else $error("result offered after reset");

  // the queue is only drained when it holds an action
  a_pop_valid : assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty queue");
`endif

endmodule

/* rtl/tcs_front.sv */
// front end: telnet sequence parser that turns data bytes and option codes into queued actions
module tcs_front (
  input  logic           clk,
  input  logic           rst,
  tcs_in_if.sink         in_ch,
  input  logic           q_full,
  output tcs_pkg::push_t push
);

  tcs_pkg::phase_t phase;
  tcs_pkg::phase_t phase_next;
  logic            refuse;
  logic            refuse_next;
  logic            accept;
  logic [7:0]      b;

  // take a byte whenever the queue has room
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign b           = in_ch.in_byte;

  // phase and pending refusal kind
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= tcs_pkg::PH_IDLE;
      refuse <= 1'b0;
    end else if (accept) begin
      phase  <= phase_next;
      refuse <= refuse_next;
    end
  end

  // next phase
  always_comb begin
    phase_next  = tcs_pkg::PH_IDLE;
    refuse_next = refuse;
    case (phase)
      tcs_pkg::PH_IDLE: begin
        if (b == tcs_pkg::CMD_IAC) phase_next = tcs_pkg::PH_CMD;
      end
      tcs_pkg::PH_CMD: begin
        if (b inside {tcs_pkg::CMD_WILL, tcs_pkg::CMD_WONT}) begin
          phase_next  = tcs_pkg::PH_OPTION;
          refuse_next = 1'b1;
        end else if (b inside {tcs_pkg::CMD_DO, tcs_pkg::CMD_DONT}) begin
          phase_next  = tcs_pkg::PH_OPTION;
          refuse_next = 1'b0;
        end
      end
      tcs_pkg::PH_OPTION: phase_next = tcs_pkg::PH_IDLE;
      default: begin
        if (b == tcs_pkg::CMD_IAC) phase_next = tcs_pkg::PH_CMD;
      end
    endcase
  end

  // action for this byte
  always_comb begin
    push.valid     = 1'b0;
    push.act.reply = 1'b0;
    push.act.dont  = refuse;
    push.act.value = b;
    case (phase)
      tcs_pkg::PH_IDLE: push.valid = accept && (b != tcs_pkg::CMD_IAC);
      tcs_pkg::PH_CMD:  push.valid = accept && (b == tcs_pkg::CMD_IAC);
      tcs_pkg::PH_OPTION: begin
        push.valid     = accept;
        push.act.reply = 1'b1;
      end
      default: push.valid = accept && (b != tcs_pkg::CMD_IAC);
    endcase
  end

endmodule

/* rtl/tcs_queue.sv */
// short action queue between parser and reply expander
module tcs_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  tcs_pkg::push_t   push,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output tcs_pkg::action_t q_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  tcs_pkg::action_t mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_CNT);
  assign q_valid = (count != '0);
  assign q_data  = mem[rd_ptr];
  assign do_push = push.valid && !full;
  assign do_pop  = pop && q_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push.act;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

/* rtl/tcs_back.sv */
// back end: expands queued actions into result items behind an output register
module tcs_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  tcs_pkg::action_t q_data,
  output logic             pop,
  tcs_out_if.source        res
);

  tcs_pkg::expand_t state;
  tcs_pkg::expand_t state_next;
  tcs_pkg::action_t cur;
  logic             out_free;
  logic             emit;
  logic             emit_channel;
  logic [7:0]       emit_byte;
  logic             emit_last;
  logic             out_valid;
  logic             out_channel;
  logic [7:0]       out_byte;
  logic             out_last;

  assign out_free = !out_valid || res.ready;

  // next step
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    case (state)
      tcs_pkg::EX_IDLE: begin
        if (out_free && q_valid) begin
          pop = 1'b1;
          if (q_data.reply) state_next = tcs_pkg::EX_VERB;
        end
      end
      tcs_pkg::EX_VERB: if (out_free) state_next = tcs_pkg::EX_OPT;
      tcs_pkg::EX_OPT:  if (out_free) state_next = tcs_pkg::EX_IDLE;
      default: state_next = tcs_pkg::EX_IDLE;
    endcase
  end

  // item to present
  always_comb begin
    emit         = 1'b0;
    emit_channel = tcs_pkg::CH_REPLY;
    emit_byte    = cur.value;
    emit_last    = 1'b0;
    case (state)
      tcs_pkg::EX_IDLE: begin
        emit         = out_free && q_valid;
        emit_channel = q_data.reply ? tcs_pkg::CH_REPLY : tcs_pkg::CH_DATA;
        emit_byte    = q_data.reply ? tcs_pkg::CMD_IAC : q_data.value;
        emit_last    = !q_data.reply;
      end
      tcs_pkg::EX_VERB: begin
        emit      = out_free;
        emit_byte = cur.dont ? tcs_pkg::CMD_DONT : tcs_pkg::CMD_WONT;
      end
      tcs_pkg::EX_OPT: begin
        emit      = out_free;
        emit_last = 1'b1;
      end
      default: emit = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tcs_pkg::EX_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_free) out_valid <= emit;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pop) cur <= q_data;
    if (emit) begin
      out_channel <= emit_channel;
      out_byte    <= emit_byte;
      out_last    <= emit_last;
    end
  end

  assign res.valid       = out_valid;
  assign res.out_channel = out_channel;
  assign res.out_byte    = out_byte;
  assign res.out_last    = out_last;

endmodule
